FILE: rtl/u16550_pkg.sv
// Package for the 16550 UART register model: transfer payload types, register
// offsets, function codes, interrupt identification codes and the RX FIFO sizing.
// Used by every other file of the block.
package u16550_pkg;

    localparam int FIFO_DEPTH = 16;
    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic [1:0] FUNC_READ  = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_LINE  = 2'd2;

    localparam logic [2:0] REG_RBR = 3'd0;
    localparam logic [2:0] REG_IER = 3'd1;
    localparam logic [2:0] REG_IIR = 3'd2;
    localparam logic [2:0] REG_LCR = 3'd3;
    localparam logic [2:0] REG_MCR = 3'd4;
    localparam logic [2:0] REG_LSR = 3'd5;
    localparam logic [2:0] REG_MSR = 3'd6;
    localparam logic [2:0] REG_SCR = 3'd7;

    localparam logic [3:0] IID_NONE = 4'h1;
    localparam logic [3:0] IID_RLS  = 4'h6;
    localparam logic [3:0] IID_RDA  = 4'h4;
    localparam logic [3:0] IID_THRE = 4'h2;
    localparam logic [3:0] IID_MS   = 4'h0;

    localparam logic [7:0] DLL_RESET = 8'h0C;
    localparam logic [7:0] LCR_RESET = 8'h03;
    localparam logic [7:0] LSR_FIXED = 8'h60;
    localparam logic [7:0] IIR_FEN   = 8'hC0;

    localparam logic [CNT_W-1:0] TRIG_1  = CNT_W'(1);
    localparam logic [CNT_W-1:0] TRIG_4  = CNT_W'(4);
    localparam logic [CNT_W-1:0] TRIG_8  = CNT_W'(8);
    localparam logic [CNT_W-1:0] TRIG_14 = CNT_W'(14);

    typedef struct packed {
        logic [1:0] func;
        logic [2:0] reg_offset;
        logic [7:0] write_data;
        logic [7:0] line_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       line_taken;
        logic       irq_out;
    } t_out_item;

    typedef struct packed {
        logic       push;
        logic       pop;
        logic       clear;
        logic [7:0] push_data;
    } t_fifo_ctl;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [CNT_W-1:0] next_count;
        logic [7:0]       head_data;
    } t_fifo_stat;

    function automatic logic [7:0] iir_value(
        input logic [3:0] ier,
        input logic       overrun,
        input logic       rda,
        input logic       thre,
        input logic       ms_delta,
        input logic       fifo_on
    );
        logic [3:0] id;
        priority if (ier[2] && overrun) begin
            id = IID_RLS;
        end else if (ier[0] && rda) begin
            id = IID_RDA;
        end else if (ier[1] && thre) begin
            id = IID_THRE;
        end else if (ier[3] && ms_delta) begin
            id = IID_MS;
        end else begin
            id = IID_NONE;
        end
        return {4'h0, id} | (fifo_on ? IIR_FEN : 8'h00);
    endfunction

    function automatic logic [CNT_W-1:0] trigger_level(
        input logic       fifo_on,
        input logic [1:0] sel
    );
        logic [CNT_W-1:0] lvl;
        if (!fifo_on) begin
            lvl = TRIG_1;
        end else begin
            unique case (sel)
                2'd0:    lvl = TRIG_1;
                2'd1:    lvl = TRIG_4;
                2'd2:    lvl = TRIG_8;
                default: lvl = TRIG_14;
            endcase
        end
        return lvl;
    endfunction

endpackage

FILE: rtl/u16550_if.sv
// Valid/ready channel interfaces for the 16550 UART register model.
// Depends on u16550_pkg for the payload types.
interface u16550_in_if import u16550_pkg::*;;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface u16550_out_if import u16550_pkg::*;;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/uart_16550_register_model_core.sv
// Top level of the 16550 UART register model: input register, register file,
// RX FIFO and result register. Depends on u16550_pkg, u16550_if, u16550_regs and
// u16550_rxfifo.
//
//  Port     Direction  Payload                                   Meaning
//  i_in     sink       func, reg_offset, write_data, line_byte   bus access or line byte
//  o_out    source     read_data, tx_valid, tx_byte,             one result per transfer
//                      line_taken, irq_out
//
// Each input transfer is held in the input register and is then resolved
// combinationally against the register file and the RX FIFO into the result register.
// One transfer is accepted every cycle while o_out takes its results.
// When o_out is stalled, the result register holds and one more transfer
// waits in the input register before i_in.ready drops.
// Synchronous active-low reset restores the documented register values and
// empties the FIFO.
module uart_16550_register_model_core import u16550_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    u16550_in_if.sink        i_in,
    u16550_out_if.source     o_out
);

    logic       r_in_valid;
    t_in_item   r_in;
    logic       r_out_valid;
    t_out_item  r_out;
    logic       advance;
    logic       go;
    t_fifo_ctl  fifo_ctl;
    t_fifo_stat fifo_stat;
    t_out_item  result;

    assign advance    = !r_out_valid || o_out.ready;
    assign go         = r_in_valid && advance;
    assign i_in.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready) begin
            r_in <= i_in.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (go) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            r_out <= result;
        end
    end

    u16550_regs u_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_go     (go),
        .i_item   (r_in),
        .i_fifo   (fifo_stat),
        .o_fifo   (fifo_ctl),
        .o_result (result)
    );

    u16550_rxfifo u_rxfifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (fifo_ctl),
        .o_stat  (fifo_stat)
    );

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    a_fifo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fifo_stat.count <= CNT_W'(FIFO_DEPTH))
        else $error("RX FIFO count exceeds its depth");

    a_line_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        go && r_in.func == FUNC_LINE && fifo_stat.count < CNT_W'(FIFO_DEPTH)
        |=> fifo_stat.count == $past(fifo_stat.count) + 1'b1)
        else $error("Accepted line byte did not enter the RX FIFO");

    a_tx_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.tx_valid |-> !r_out.line_taken && r_out.read_data == 8'h00)
        else $error("Transmit result mixed with read or line results");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> r_in_valid && r_out_valid && !o_out.ready)
        else $error("Input stalled without a full pipeline");

endmodule

FILE: rtl/u16550_rxfifo.sv
// Receive FIFO of the 16550 UART register model: storage, head and tail pointers
// and fill count. Depends on u16550_pkg.
module u16550_rxfifo import u16550_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_fifo_ctl  i_ctl,
    output t_fifo_stat o_stat
);

    logic [7:0]       r_store [FIFO_DEPTH];
    logic [PTR_W-1:0] r_head, n_head;
    logic [PTR_W-1:0] r_tail, n_tail;
    logic [CNT_W-1:0] r_count, n_count;
    logic [7:0]       r_head_data;
    logic             push_ok;
    logic             pop_ok;

    always_comb begin
        push_ok = i_ctl.push && (r_count < CNT_W'(FIFO_DEPTH));
        pop_ok  = i_ctl.pop && (r_count != '0);
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        if (i_ctl.clear) begin
            n_head  = '0;
            n_tail  = '0;
            n_count = '0;
        end else if (push_ok) begin
            n_tail  = (r_tail == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_tail + 1'b1;
            n_count = r_count + 1'b1;
        end else if (pop_ok) begin
            n_head  = (r_head == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_head + 1'b1;
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    // The head byte is registered from the next head pointer; a push into an empty FIFO
    // lands at the new head and is forwarded.
    always_ff @(posedge i_clk) begin
        if (push_ok && !i_ctl.clear) begin
            r_store[r_tail] <= i_ctl.push_data;
        end
        if (push_ok && !i_ctl.clear && r_tail == n_head) begin
            r_head_data <= i_ctl.push_data;
        end else begin
            r_head_data <= r_store[n_head];
        end
    end

    assign o_stat.count      = r_count;
    assign o_stat.next_count = n_count;
    assign o_stat.head_data  = r_head_data;

endmodule

FILE: rtl/u16550_regs.sv
// Register file and per-transfer update logic of the 16550 UART register model.
// Depends on u16550_pkg; drives the RX FIFO controls and forms the result.
module u16550_regs import u16550_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_go,
    input  t_in_item   i_item,
    input  t_fifo_stat i_fifo,
    output t_fifo_ctl  o_fifo,
    output t_out_item  o_result
);

    logic [7:0] r_dll, n_dll;
    logic [7:0] r_dlm, n_dlm;
    logic [3:0] r_ier, n_ier;
    logic [7:0] r_lcr, n_lcr;
    logic [4:0] r_mcr, n_mcr;
    logic [7:0] r_msr, n_msr;
    logic [7:0] r_scr, n_scr;
    logic [7:0] r_fcr, n_fcr;
    logic       r_fifo_on, n_fifo_on;
    logic       r_thre, n_thre;
    logic       r_overrun, n_overrun;

    logic       dlab;
    logic       full;
    logic [7:0] cur_iir;
    logic [7:0] next_iir;
    logic [3:0] mirror;
    logic       push, pop, clear;

    always_comb begin
        dlab    = r_lcr[7];
        full    = (i_fifo.count >= CNT_W'(FIFO_DEPTH));
        cur_iir = iir_value(r_ier, r_overrun,
                            i_fifo.count >= trigger_level(r_fifo_on, r_fcr[7:6]),
                            r_thre, r_msr[3:0] != 4'h0, r_fifo_on);
        mirror  = {i_item.write_data[3], i_item.write_data[2],
                   i_item.write_data[0], i_item.write_data[1]};

        n_dll     = r_dll;
        n_dlm     = r_dlm;
        n_ier     = r_ier;
        n_lcr     = r_lcr;
        n_mcr     = r_mcr;
        n_msr     = r_msr;
        n_scr     = r_scr;
        n_fcr     = r_fcr;
        n_fifo_on = r_fifo_on;
        n_thre    = r_thre;
        n_overrun = r_overrun;
        push      = 1'b0;
        pop       = 1'b0;
        clear     = 1'b0;
        o_result  = '0;

        unique case (i_item.func)
            FUNC_READ: begin
                unique case (i_item.reg_offset)
                    REG_RBR: begin
                        if (dlab) begin
                            o_result.read_data = r_dll;
                        end else begin
                            pop = 1'b1;
                            o_result.read_data = (i_fifo.count != '0) ? i_fifo.head_data
                                                                      : 8'h00;
                        end
                    end
                    REG_IER: o_result.read_data = dlab ? r_dlm : {4'h0, r_ier};
                    REG_IIR: begin
                        o_result.read_data = cur_iir;
                        if (cur_iir[3:0] == IID_THRE) begin
                            n_thre = 1'b0;
                        end
                    end
                    REG_LCR: o_result.read_data = r_lcr;
                    REG_MCR: o_result.read_data = {3'h0, r_mcr};
                    REG_LSR: begin
                        o_result.read_data = LSR_FIXED | {6'h0, r_overrun,
                                                          i_fifo.count != '0};
                        n_overrun = 1'b0;
                    end
                    REG_MSR: begin
                        o_result.read_data = r_msr;
                        n_msr = {r_msr[7:4], 4'h0};
                    end
                    REG_SCR: o_result.read_data = r_scr;
                    default: o_result.read_data = 8'h00;
                endcase
            end
            FUNC_WRITE: begin
                unique case (i_item.reg_offset)
                    REG_RBR: begin
                        if (dlab) begin
                            n_dll = i_item.write_data;
                        end else begin
                            if (r_mcr[4]) begin
                                push = 1'b1;
                                if (full) begin
                                    n_overrun = 1'b1;
                                end
                            end else begin
                                o_result.tx_valid = 1'b1;
                                o_result.tx_byte  = i_item.write_data;
                            end
                            n_thre = 1'b1;
                        end
                    end
                    REG_IER: begin
                        if (dlab) begin
                            n_dlm = i_item.write_data;
                        end else begin
                            n_ier = i_item.write_data[3:0];
                            if (i_item.write_data[1]) begin
                                n_thre = 1'b1;
                            end
                        end
                    end
                    REG_IIR: begin
                        n_fcr     = i_item.write_data;
                        n_fifo_on = i_item.write_data[0];
                        clear     = (i_item.write_data[0] && !r_fifo_on)
                                    || i_item.write_data[1];
                    end
                    REG_LCR: n_lcr = i_item.write_data;
                    REG_MCR: begin
                        n_mcr = i_item.write_data[4:0];
                        if (i_item.write_data[4]) begin
                            n_msr = {mirror, r_msr[3:0] | (r_msr[7:4] ^ mirror)};
                        end
                    end
                    REG_SCR: n_scr = i_item.write_data;
                    default: begin
                    end
                endcase
            end
            FUNC_LINE: begin
                push = 1'b1;
                o_result.line_taken = !full;
            end
            default: begin
            end
        endcase

        next_iir = iir_value(n_ier, n_overrun,
                             i_fifo.next_count >= trigger_level(n_fifo_on, n_fcr[7:6]),
                             n_thre, n_msr[3:0] != 4'h0, n_fifo_on);
        o_result.irq_out = !next_iir[0];

        o_fifo.push  = i_go && push;
        o_fifo.pop   = i_go && pop;
        o_fifo.clear = i_go && clear;
        o_fifo.push_data = (i_item.func == FUNC_LINE) ? i_item.line_byte
                                                      : i_item.write_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dll     <= DLL_RESET;
            r_dlm     <= '0;
            r_ier     <= '0;
            r_lcr     <= LCR_RESET;
            r_mcr     <= '0;
            r_msr     <= '0;
            r_scr     <= '0;
            r_fcr     <= '0;
            r_fifo_on <= 1'b0;
            r_thre    <= 1'b0;
            r_overrun <= 1'b0;
        end else if (i_go) begin
            r_dll     <= n_dll;
            r_dlm     <= n_dlm;
            r_ier     <= n_ier;
            r_lcr     <= n_lcr;
            r_mcr     <= n_mcr;
            r_msr     <= n_msr;
            r_scr     <= n_scr;
            r_fcr     <= n_fcr;
            r_fifo_on <= n_fifo_on;
            r_thre    <= n_thre;
            r_overrun <= n_overrun;
        end
    end

endmodule
